### rtl/mlad_pkg.sv
// Shared types, constants and command codes for the ladder lowpass filter.
package mlad_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int STATE_BITS_DEF  = 32;
  localparam int COEF_BITS       = 24;
  localparam int COEF_FRAC       = 20;
  localparam int SIXTH_FRAC      = 30;
  localparam int DIGIT_BITS      = 16;
  localparam int CFG_ADDR_BITS   = 2;

  // One sixth with 30 fraction bits, rounded.
  localparam logic [29:0] SIXTH_Q30 = 30'd178956971;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_STAGE_GAIN     = 2'd0,
    REG_STAGE_FEEDBACK = 2'd1,
    REG_RESONANCE_GAIN = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SH_COEF,
    SH_STATE,
    SH_SIXTH
  } shift_sel_t;

  typedef enum logic [2:0] {
    MS_RES,
    MS_GAIN,
    MS_FB,
    MS_SQ,
    MS_CUBE,
    MS_SIXTH
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RES,
    OP_SUM,
    OP_KEEP,
    OP_STAGE,
    OP_FINAL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   msel;
    logic       mul_start;
    logic [1:0] stage;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

endpackage

### rtl/mlad_mul.sv
// Shared multiplier: digit-serial signed product, floor shift and saturation.
module mlad_mul #(
  parameter int MUL_BITS   = 32,
  parameter int STATE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [MUL_BITS-1:0]     a,
  input  logic signed [MUL_BITS-1:0]     b,
  input  mlad_pkg::shift_sel_t           shift_sel,
  output logic                           done,
  output logic signed [STATE_BITS-1:0]   p
);
  import mlad_pkg::*;

  localparam int NDIG       = (MUL_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BPW        = NDIG * DIGIT_BITS;
  localparam int AW         = MUL_BITS + BPW;
  localparam int CW         = $clog2(NDIG);
  localparam int PPW        = MUL_BITS + DIGIT_BITS + 1;
  localparam int STATE_FRAC = STATE_BITS - 5;

  logic signed [MUL_BITS-1:0]   a_r;
  logic [BPW-1:0]               b_r;
  logic signed [AW-1:0]         acc_r, acc_nxt;
  logic [CW-1:0]                cnt_r;
  logic                         busy_r, fin_r, done_r;
  shift_sel_t                   sh_r;
  logic signed [STATE_BITS-1:0] p_r, p_nxt;

  logic [DIGIT_BITS-1:0]        dig;
  logic signed [DIGIT_BITS:0]   dig_s;
  logic signed [PPW-1:0]        pp;
  logic signed [AW-1:0]         shifted;
  logic [AW-STATE_BITS:0]       hi;

  // Top digit carries the sign, lower digits are unsigned.
  always_comb begin
    dig     = b_r[cnt_r*DIGIT_BITS +: DIGIT_BITS];
    dig_s   = (cnt_r == CW'(NDIG - 1)) ? {dig[DIGIT_BITS-1], dig} : {1'b0, dig};
    pp      = a_r * dig_s;
    acc_nxt = (acc_r <<< DIGIT_BITS) + AW'(pp);
  end

  always_comb begin
    case (sh_r)
      SH_STATE: shifted = acc_r >>> STATE_FRAC;
      SH_SIXTH: shifted = acc_r >>> SIXTH_FRAC;
      default:  shifted = acc_r >>> COEF_FRAC;
    endcase
    hi = shifted[AW-1:STATE_BITS-1];
    if ((&hi) || !(|hi)) begin
      p_nxt = shifted[STATE_BITS-1:0];
    end else begin
      p_nxt = {shifted[AW-1], {(STATE_BITS-1){~shifted[AW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NDIG - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BPW'(b);
      sh_r  <= shift_sel;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
    if (fin_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

### rtl/mlad_dp.sv
// Datapath: filter state, stage ring, operand selection and the shared multiplier.
module mlad_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mlad_pkg::ctrl_cmd_t                     cmd,
  output mlad_pkg::dp_sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample,
  input  logic                                    in_last,
  input  logic signed [mlad_pkg::COEF_BITS-1:0]   stage_gain,
  input  logic signed [mlad_pkg::COEF_BITS-1:0]   stage_feedback,
  input  logic signed [mlad_pkg::COEF_BITS-1:0]   resonance_gain,
  output logic signed [SAMPLE_BITS-1:0]           out_sample,
  output logic                                    out_last
);
  import mlad_pkg::*;

  localparam int SB   = STATE_BITS;
  localparam int SF   = SB - 5;
  localparam int SAF  = SAMPLE_BITS - 1;
  localparam int LSH  = (SF >= SAF) ? (SF - SAF) : 0;
  localparam int RSH  = (SAF > SF) ? (SAF - SF) : 0;
  localparam int MW   = (SB > 31) ? SB : 31;
  localparam int CVW  = SB + SAMPLE_BITS;

  function automatic logic signed [SB-1:0] sat_st(input logic signed [SB:0] v);
    if (v[SB] == v[SB-1]) begin
      return v[SB-1:0];
    end
    return {v[SB], {(SB-1){~v[SB]}}};
  endfunction

  // ring_r[0] is the stage being updated, ring_r[3] the one updated last;
  // between samples ring_r[3] holds the fourth stage.
  logic signed [SB-1:0] ring_r [4];
  logic signed [SB-1:0] prev_r, x_r, sum_r, t_r, old_r, stage_new;
  logic                 last_r;

  logic signed [SB-1:0]  p;
  logic                  mul_done;
  logic signed [MW-1:0]  mul_a, mul_b;
  shift_sel_t            mul_sh;

  logic signed [CVW-1:0] x_wide, y_wide;
  logic signed [SB-1:0]  x_conv, st_in, st_prev;

  always_comb begin
    x_wide = (CVW'(in_sample) <<< LSH) >>> RSH;
    if ((&x_wide[CVW-1:SB-1]) || !(|x_wide[CVW-1:SB-1])) begin
      x_conv = x_wide[SB-1:0];
    end else begin
      x_conv = {x_wide[CVW-1], {(SB-1){~x_wide[CVW-1]}}};
    end
    y_wide = (CVW'(ring_r[3]) <<< RSH) >>> LSH;
    if ((&y_wide[CVW-1:SAMPLE_BITS-1]) || !(|y_wide[CVW-1:SAMPLE_BITS-1])) begin
      out_sample = y_wide[SAMPLE_BITS-1:0];
    end else begin
      out_sample = {y_wide[CVW-1], {(SAMPLE_BITS-1){~y_wide[CVW-1]}}};
    end
  end

  always_comb begin
    st_in     = (cmd.stage == 2'd0) ? x_r : ring_r[3];
    st_prev   = (cmd.stage == 2'd0) ? prev_r : old_r;
    stage_new = sat_st({t_r[SB-1], t_r} - {p[SB-1], p});
  end

  always_comb begin
    mul_sh = SH_COEF;
    unique case (cmd.msel)
      MS_RES: begin
        mul_a = MW'(resonance_gain);
        mul_b = MW'(ring_r[3]);
      end
      MS_GAIN: begin
        mul_a = MW'(sum_r);
        mul_b = MW'(stage_gain);
      end
      MS_FB: begin
        mul_a = MW'(ring_r[0]);
        mul_b = MW'(stage_feedback);
      end
      MS_SQ: begin
        mul_a  = MW'(ring_r[3]);
        mul_b  = MW'(ring_r[3]);
        mul_sh = SH_STATE;
      end
      MS_CUBE: begin
        mul_a  = MW'(t_r);
        mul_b  = MW'(ring_r[3]);
        mul_sh = SH_STATE;
      end
      MS_SIXTH: begin
        mul_a  = MW'(t_r);
        mul_b  = MW'($signed({1'b0, SIXTH_Q30}));
        mul_sh = SH_SIXTH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mlad_mul #(
    .MUL_BITS   (MW),
    .STATE_BITS (SB)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mul_start),
    .a         (mul_a),
    .b         (mul_b),
    .shift_sel (mul_sh),
    .done      (mul_done),
    .p         (p)
  );

  // Filter state: cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      for (int i = 0; i < 4; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_STAGE: begin
          ring_r[0] <= ring_r[1];
          ring_r[1] <= ring_r[2];
          ring_r[2] <= ring_r[3];
          ring_r[3] <= stage_new;
        end
        OP_FINAL: begin
          ring_r[3] <= sat_st({ring_r[3][SB-1], ring_r[3]} - {t_r[SB-1], t_r});
          prev_r    <= x_r;
        end
        default: ;
      endcase
    end
  end

  // Working registers for the sample in flight.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r    <= x_conv;
        last_r <= in_last;
      end
      OP_RES:   x_r   <= sat_st({x_r[SB-1], x_r} - {p[SB-1], p});
      OP_SUM:   sum_r <= sat_st({st_in[SB-1], st_in} + {st_prev[SB-1], st_prev});
      OP_KEEP:  t_r   <= p;
      OP_STAGE: old_r <= ring_r[0];
      default: ;
    endcase
  end

  assign sts.mul_done = mul_done;
  assign out_last     = last_r;

endmodule

### rtl/mlad_ctrl.sv
// Controller: sequences the twelve multiplies and the state updates of one sample.
module mlad_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  mlad_pkg::dp_sts_t   sts,
  output logic                in_ready,
  output mlad_pkg::ctrl_cmd_t cmd
);
  import mlad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_GO,
    S_RES_W,
    S_SUM,
    S_GAIN_GO,
    S_GAIN_W,
    S_FB_GO,
    S_FB_W,
    S_SQ_GO,
    S_SQ_W,
    S_CU_GO,
    S_CU_W,
    S_SX_GO,
    S_SX_W,
    S_FINAL,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.msel      = MS_RES;
    cmd.mul_start = 1'b0;
    cmd.stage     = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_RES_GO;
        end
      end
      S_RES_GO: begin
        cmd.msel      = MS_RES;
        cmd.mul_start = 1'b1;
        state_nxt     = S_RES_W;
      end
      S_RES_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_RES;
          k_nxt     = 2'd0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_GAIN_GO;
      end
      S_GAIN_GO: begin
        cmd.msel      = MS_GAIN;
        cmd.mul_start = 1'b1;
        state_nxt     = S_GAIN_W;
      end
      S_GAIN_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_KEEP;
          state_nxt = S_FB_GO;
        end
      end
      S_FB_GO: begin
        cmd.msel      = MS_FB;
        cmd.mul_start = 1'b1;
        state_nxt     = S_FB_W;
      end
      S_FB_W: begin
        if (sts.mul_done) begin
          cmd.op = OP_STAGE;
          k_nxt  = k_r + 2'd1;
          state_nxt = (k_r == 2'd3) ? S_SQ_GO : S_SUM;
        end
      end
      S_SQ_GO: begin
        cmd.msel      = MS_SQ;
        cmd.mul_start = 1'b1;
        state_nxt     = S_SQ_W;
      end
      S_SQ_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_KEEP;
          state_nxt = S_CU_GO;
        end
      end
      S_CU_GO: begin
        cmd.msel      = MS_CUBE;
        cmd.mul_start = 1'b1;
        state_nxt     = S_CU_W;
      end
      S_CU_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_KEEP;
          state_nxt = S_SX_GO;
        end
      end
      S_SX_GO: begin
        cmd.msel      = MS_SIXTH;
        cmd.mul_start = 1'b1;
        state_nxt     = S_SX_W;
      end
      S_SX_W: begin
        if (sts.mul_done) begin
          cmd.op    = OP_KEEP;
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.op    = OP_FINAL;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/moog_ladder_lowpass_filter_core.sv
// One input word is processed at a time: no new word is taken until the last result is emitted.
// Each sample takes twelve multiplies on one shared 16-bit-digit serial multiplier,
// with NDIG = ceil(max(STATE_BITS,31)/16) digits per operand.
// A finished word waits in the output register while the next input word is taken.
// Reset (rst_n low, synchronous) clears the filter state, the coefficients and all handshakes.
module moog_ladder_lowpass_filter_core #(
  parameter int SAMPLE_BITS = mlad_pkg::SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = mlad_pkg::STATE_BITS_DEF,
  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [mlad_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [mlad_pkg::COEF_BITS-1:0]       cfg_wdata,
  // input sample stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [TDATA_BITS-1:0]                in_tdata,   // sample_in
  input  logic                                 in_tlast,   // last_in
  // output sample stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [TDATA_BITS-1:0]                out_tdata,  // sample_out, zero padded
  output logic                                 out_tlast   // last_out
);
  import mlad_pkg::*;

  // Coefficients, all signed Q3.20.
  logic signed [COEF_BITS-1:0] stage_gain_r, stage_feedback_r, resonance_gain_r;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_last_r;
  logic signed [SAMPLE_BITS-1:0] dp_sample;
  logic                          dp_last;
  logic                          out_free, emit;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_gain_r     <= '0;
      stage_feedback_r <= '0;
      resonance_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_STAGE_GAIN:     stage_gain_r     <= cfg_wdata;
        REG_STAGE_FEEDBACK: stage_feedback_r <= cfg_wdata;
        REG_RESONANCE_GAIN: resonance_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle its word is taken.
  assign out_free = !out_valid_r || out_tready;
  assign emit     = (cmd.op == OP_EMIT);

  mlad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  mlad_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_last        (in_tlast),
    .stage_gain     (stage_gain_r),
    .stage_feedback (stage_feedback_r),
    .resonance_gain (resonance_gain_r),
    .out_sample     (dp_sample),
    .out_last       (dp_last)
  );

  // Output register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample_r <= dp_sample;
      out_last_r   <= dp_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_BITS'(out_sample_r);
  assign out_tlast  = out_last_r;

  // One sample in flight: no new word right after one is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a sample is in flight");

  // Never overwrite a word still waiting at the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_tready))
    else $error("output word overwritten");

  // After a result is emitted the block is ready for the next word.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> in_tready)
    else $error("not ready after emit");

endmodule

### sim/tb_moog_ladder_lowpass_filter_core.sv
// Self-checking bench for the four-pole ladder lowpass core: predicted vs streamed samples.
`timescale 1ns / 1ps

module tb_moog_ladder_lowpass_filter_core;
  import mlad_pkg::*;

  // Arithmetic of the ladder: Q4.27 state, Q0.23 samples, Q3.20 coefficients
  localparam int     STATE_Q    = 27;
  localparam int     SAMPLE_Q   = 23;
  localparam int     COEF_Q     = 20;
  localparam int     SIXTH_Q    = 30;
  localparam longint ONE_SIXTH  = 178956971;
  localparam longint STATE_MAX  = 2147483647;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint SAMPLE_MAX = 8388607;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int     COEF_ONE   = 1 << COEF_Q;

  // Run control
  localparam int DRAIN_CYCLES    = 80;      // settle time after the queue empties
  localparam int HOLD_OFF_CYCLES = 500;     // long enough to back up two words
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASE_WORDS     = 75;
  localparam int NUM_PHASES      = 8;

  // No register sits behind this index; writes to it must change nothing
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

  typedef enum int {CF_TUNED, CF_RANDOM, CF_EXTREME} coef_style_t;

  typedef struct packed {
    logic [23:0] smp;
    logic        tlast_bit;
  } filter_word_t;

  // Tracks coefficients and ladder state, predicts each output word and
  // compares the stream against the predictions in order.
  class ladder_tracker;
    longint gain, feedback, resonance;
    longint prev_x, pole1, pole2, pole3, pole4;
    filter_word_t filtered_q[$];
    int errors, n_in, n_out;

    function new();
      gain = 0; feedback = 0; resonance = 0;
      prev_x = 0; pole1 = 0; pole2 = 0; pole3 = 0; pole4 = 0;
      errors = 0; n_in = 0; n_out = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [COEF_BITS-1:0] value);
      longint v;
      v = longint'($signed(value));
      case (idx)
        REG_STAGE_GAIN:     gain = v;
        REG_STAGE_FEEDBACK: feedback = v;
        REG_RESONANCE_GAIN: resonance = v;
        default: ;
      endcase
    endfunction

    function longint sat_state(longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v;
    endfunction

    // Floor of the scaled product, then clamp to the state range
    function longint mul_floor(longint a, longint b, int sh);
      longint p;
      p = a * b;
      return sat_state(p >>> sh);
    endfunction

    function longint ladder_pole(longint x, longint x_old, longint st);
      return sat_state(mul_floor(sat_state(x + x_old), gain, COEF_Q) -
                       mul_floor(st, feedback, COEF_Q));
    endfunction

    function logic [23:0] run_ladder(logic [23:0] din);
      longint x, o1, o2, o3, cube, y;
      x = longint'($signed(din)) <<< (STATE_Q - SAMPLE_Q);
      x = sat_state(x - mul_floor(resonance, pole4, COEF_Q));
      o1 = pole1;
      o2 = pole2;
      o3 = pole3;
      pole1 = ladder_pole(x, prev_x, pole1);
      pole2 = ladder_pole(pole1, o1, pole2);
      pole3 = ladder_pole(pole2, o2, pole3);
      pole4 = ladder_pole(pole3, o3, pole4);
      cube = mul_floor(pole4, pole4, STATE_Q);
      cube = mul_floor(cube, pole4, STATE_Q);
      cube = mul_floor(cube, ONE_SIXTH, SIXTH_Q);
      pole4 = sat_state(pole4 - cube);
      prev_x = x;
      y = pole4 >>> (STATE_Q - SAMPLE_Q);
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      return y[23:0];
    endfunction

    function void take_sample(logic [23:0] din, logic tl);
      filter_word_t w;
      w.smp = run_ladder(din);
      w.tlast_bit = tl;
      filtered_q.push_back(w);
      n_in++;
    endfunction

    function void match_output(logic [23:0] dout, logic tl);
      filter_word_t w;
      n_out++;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: output word with nothing expected: sample %h last %b", $time, dout, tl);
        return;
      end
      w = filtered_q.pop_front();
      if (dout !== w.smp) begin
        errors++;
        $display("%0t: sample_out mismatch: expected %h (%0d) actual %h (%0d)", $time,
                 w.smp, $signed(w.smp), dout, $signed(dout));
      end
      if (tl !== w.tlast_bit) begin
        errors++;
        $display("%0t: last_out mismatch: expected %b actual %b", $time, w.tlast_bit, tl);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [COEF_BITS-1:0]     cfg_wdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [23:0]              in_tdata;   // sample_in
  logic                     in_tlast;   // last_in
  logic                     out_tvalid;
  logic                     out_tready;
  logic [23:0]              out_tdata;  // sample_out
  logic                     out_tlast;  // last_out

  ladder_tracker trk;
  int cycle_count = 0;
  int hold_off_cycles = 0;   // set by the stimulus, consumed by the receiver
  int n_settings = 0;

  moog_ladder_lowpass_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Check every output word taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      trk.match_output(out_tdata, out_tlast);
  end

  // Receiver: random segments of always-ready, coin-flip, fixed duty and
  // mostly-stalled behavior; a requested hold-off overrides all of them.
  initial begin
    bit rdy;
    int seg_left, mode, hold_left;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 300);
        end
        seg_left--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (seg_left % 7) < 5;
          default: rdy = ($urandom_range(0, 9) == 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Offer one word and hold it until taken; call and return at a falling edge
  task automatic send_word(input logic [23:0] din, input logic tl);
    in_tvalid <= 1'b1;
    in_tdata  <= din;
    in_tlast  <= tl;
    do @(posedge clk); while (in_tready !== 1'b1);
    trk.take_sample(din, tl);
    @(negedge clk);
  endtask

  // Drop valid for a gap; a zero gap keeps valid high for the next word
  task automatic end_burst(input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tlast  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Pause the sender until every predicted word has come back, then let
  // the pipeline settle before touching the registers
  task automatic wait_drained();
    while (trk.filtered_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    trk.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_coefs(input logic [23:0] g, input logic [23:0] f,
                               input logic [23:0] q);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE, 24'($urandom));
    write_reg(REG_STAGE_GAIN, g);
    write_reg(REG_STAGE_FEEDBACK, f);
    write_reg(REG_RESONANCE_GAIN, q);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [23:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'h000001;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Mostly full-range noise, with quiet passages and rail values mixed in
  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1:    return pick_extreme();
      2, 3:    return 24'($urandom_range(0, 8191) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6, 7: return $urandom_range(1, 10);
      8:          return $urandom_range(11, 40);
      default:    return $urandom_range(41, 90);
    endcase
  endfunction

  // Tuned sets follow the usual ladder relation f = 2*g - 1 with moderate
  // resonance; the others hit random and saturating coefficient corners.
  task automatic pick_coefs(input coef_style_t style);
    int g;
    case (style)
      CF_TUNED: begin
        g = $urandom_range(0, COEF_ONE / 2);
        program_coefs(24'(g), 24'(2 * g - COEF_ONE), 24'($urandom_range(0, 4 * COEF_ONE)));
      end
      CF_RANDOM: program_coefs(24'($urandom), 24'($urandom), 24'($urandom));
      default:   program_coefs(pick_extreme(), pick_extreme(), pick_extreme());
    endcase
  endtask

  task automatic run_phase(input int n_words);
    int sent, burst;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n_words; i++) begin
        send_word(pick_sample(), ($urandom_range(0, 7) == 0));
        sent++;
      end
      end_burst(pick_gap());
    end
    end_burst(1);
  endtask

  initial begin
    coef_style_t style;
    trk        = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_STAGE_GAIN;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Coefficients still at reset: the ladder must pass nothing
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h800000, 1'b1);
    end_burst(1);
    wait_drained();

    // Rails on every coefficient: drive all sums, products and the clip
    // into saturation; the spare index must not disturb anything
    write_reg(REG_SPARE, 24'h5A5A5A);
    program_coefs(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h7FFFFF, 1'b1);
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h800000, 1'b1);
    send_word(24'h800000, 1'b0);
    send_word(24'h000000, 1'b1);
    send_word(24'h000001, 1'b0);
    send_word(24'hFFFFFF, 1'b1);
    send_word(24'h555555, 1'b0);
    send_word(24'hAAAAAA, 1'b1);
    end_burst(1);
    wait_drained();

    // Opposite rails: negative gain and resonance, positive self feedback
    program_coefs(24'h800000, 24'h7FFFFF, 24'h800000);
    send_word(24'h800000, 1'b0);
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h800000, 1'b0);
    send_word(24'h7FFFFF, 1'b1);
    end_burst(1);
    wait_drained();

    // Tuned low cutoff with strong resonance: impulse and ringing tail
    program_coefs(24'(COEF_ONE / 10), 24'(COEF_ONE / 5 - COEF_ONE), 24'(2 * COEF_ONE));
    send_word(24'h7FFFFF, 1'b0);
    send_word(24'h000000, 1'b0);
    send_word(24'h000000, 1'b0);
    send_word(24'h000000, 1'b0);
    send_word(24'h800000, 1'b0);
    send_word(24'h000000, 1'b1);
    end_burst(1);
    wait_drained();

    // Random phases; the second one backs the block up behind a long
    // receiver hold-off while the sender keeps offering words
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        1:       style = CF_RANDOM;
        3:       style = CF_EXTREME;
        default: style = CF_TUNED;
      endcase
      pick_coefs(style);
      if (ph == 1) hold_off_cycles = HOLD_OFF_CYCLES;
      run_phase(PHASE_WORDS);
      wait_drained();
    end

    $display("Checked %0d output words against %0d predicted samples under %0d coefficient sets",
             trk.n_out, trk.n_in, n_settings);
    $display("(reset, rail, tuned and random coefficients; bursty input, stalled output)");
    if (trk.errors == 0 && trk.filtered_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d predicted words never seen",
               trk.errors, trk.filtered_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### moog_ladder_lowpass_filter_core.f
rtl/mlad_pkg.sv
rtl/mlad_mul.sv
rtl/mlad_dp.sv
rtl/mlad_ctrl.sv
rtl/moog_ladder_lowpass_filter_core.sv
sim/tb_moog_ladder_lowpass_filter_core.sv
